// File: hw/rtl/frp_pkg.sv
// Shared types and constants of the FASTA record parser.
// Holds the item structs, the input kinds, result codes and byte classes.
// No dependencies.
`default_nettype none

package frp_pkg;

    localparam int ALPHABET_SIZE = 256;
    localparam int BYTE_W        = 8;
    localparam int MAP_REGS      = 8;
    localparam int MAP_W         = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int FIELD_W       = 32;

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_EOF     = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    localparam logic [3:0] EV_HDR_BYTE     = 4'd0;
    localparam logic [3:0] EV_HDR_END      = 4'd1;
    localparam logic [3:0] EV_SEQ_BYTE     = 4'd2;
    localparam logic [3:0] EV_REC_END      = 4'd3;
    localparam logic [3:0] EV_BAD_HEADER   = 4'd4;
    localparam logic [3:0] EV_ILL_PRINT    = 4'd5;
    localparam logic [3:0] EV_ILL_UNPRINT  = 4'd6;
    localparam logic [3:0] EV_EOF          = 4'd7;
    localparam logic [3:0] EV_STRIP        = 4'd8;

    localparam logic [1:0] CLS_STRIP  = 2'd0;
    localparam logic [1:0] CLS_LEGAL  = 2'd1;
    localparam logic [1:0] CLS_FATAL  = 2'd2;
    localparam logic [1:0] CLS_SILENT = 2'd3;

    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_PRINT_MIN = 8'd32;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [7:0]  out_byte;
        logic [31:0] header_length;
        logic [31:0] sequence_length;
        logic [31:0] record_index;
        logic [31:0] line_number;
        logic [31:0] stripped_total;
        logic [31:0] stripped_of_byte;
    } t_out_item;

endpackage

`default_nettype wire

// File: hw/rtl/fasta_record_parser.sv
// FASTA record parser top level: input stage, parse state, output register.
// Depends on frp_pkg and frp_hist.
//
// Usage: file bytes, end-of-file marks and restarts enter on the input
// channel (i_in_valid / o_in_ready, payload i_in). Each item gives zero or
// one result on the output channel (o_out_valid / i_out_ready, payload o_out).
// The byte class map is written through i_cfg_we / i_cfg_index / i_cfg_data
// while no item is in flight.
// Output: each result passes the input stage, then the output register.
// Throughput: one item per cycle unless stalled, set by the strip histogram
// read-modify-write, whose memory read is registered and whose write is
// forwarded to an immediately following read of the same byte value.
// Reset: synchronous, active low; clears the class map, the histogram valid
// bits and all counters but the line number, which it sets to one, so the
// block is ready right after reset; a restart item clears the histogram too.
// Stall: while a result waits, the input stage still takes one more item;
// further items wait until the output register is taken.
`default_nettype none

module fasta_record_parser
    import frp_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [MAP_W-1:0]     i_cfg_data
);

    localparam logic [2:0] MODE_EXPECT = 3'd0;
    localparam logic [2:0] MODE_HEADER = 3'd1;
    localparam logic [2:0] MODE_HSKIP  = 3'd2;
    localparam logic [2:0] MODE_LSTART = 3'd3;
    localparam logic [2:0] MODE_SEQ    = 3'd4;
    localparam logic [2:0] MODE_DONE   = 3'd5;
    localparam logic [2:0] MODE_ERROR  = 3'd6;

    localparam logic [COUNT_WIDTH-1:0] CntMax = '1;
    localparam logic [COUNT_WIDTH-1:0] CntOne = COUNT_WIDTH'(1);

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == CntMax) ? v : v + CntOne;
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input logic [COUNT_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[FIELD_W-1:0];
    endfunction

    logic [MAP_W-1:0]       r_map [MAP_REGS];
    logic                   r_s1_valid;
    t_in_item               r_s1_item;
    logic [2:0]             r_mode, n_mode;
    logic [COUNT_WIDTH-1:0] r_line, n_line;
    logic [COUNT_WIDTH-1:0] r_hcnt, n_hcnt;
    logic [COUNT_WIDTH-1:0] r_scnt, n_scnt;
    logic [COUNT_WIDTH-1:0] r_rec, n_rec;
    logic [COUNT_WIDTH-1:0] r_stot, n_stot;
    logic                   r_out_valid;
    t_out_item              r_out, n_out;

    logic                   s1_go;
    logic                   in_accept;
    logic                   emit;
    logic                   use_old_len;
    logic [3:0]             ev;
    logic [7:0]             ob;
    logic [COUNT_WIDTH-1:0] of_byte;
    logic                   do_seq;
    logic [1:0]             cls;
    logic [7:0]             b;
    logic                   hist_clear;
    logic                   hist_we;
    logic [COUNT_WIDTH-1:0] hist_count;
    logic [COUNT_WIDTH-1:0] hist_new;

    assign s1_go      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_accept  = i_in_valid && o_in_ready;
    assign b          = r_s1_item.data_byte;
    assign cls        = r_map[b[7:5]][{b[4:0], 1'b0} +: 2];
    assign hist_new   = sat_inc(hist_count);

    frp_hist #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_hist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (in_accept),
        .i_rd_addr(i_in.data_byte),
        .i_clear  (hist_clear),
        .i_wr_en  (hist_we),
        .i_wr_addr(b),
        .i_wr_data(hist_new),
        .o_count  (hist_count)
    );

    always_comb begin
        n_mode      = r_mode;
        n_line      = r_line;
        n_hcnt      = r_hcnt;
        n_scnt      = r_scnt;
        n_rec       = r_rec;
        n_stot      = r_stot;
        emit        = 1'b0;
        use_old_len = 1'b0;
        ev          = EV_EOF;
        ob          = '0;
        of_byte     = '0;
        do_seq      = 1'b0;
        hist_clear  = 1'b0;
        hist_we     = 1'b0;

        unique case (r_s1_item.kind)
            KIND_RESTART: begin
                n_mode     = MODE_EXPECT;
                n_line     = CntOne;
                n_hcnt     = '0;
                n_scnt     = '0;
                n_stot     = '0;
                hist_clear = s1_go;
            end
            KIND_EOF: begin
                emit = 1'b1;
                if (r_mode == MODE_HEADER || r_mode == MODE_HSKIP ||
                    r_mode == MODE_LSTART || r_mode == MODE_SEQ) begin
                    ev          = EV_REC_END;
                    use_old_len = 1'b1;
                    n_mode      = MODE_DONE;
                    n_rec       = sat_inc(r_rec);
                    n_hcnt      = '0;
                    n_scnt      = '0;
                end else begin
                    ev = EV_EOF;
                end
            end
            KIND_BYTE: begin
                unique case (r_mode)
                    MODE_EXPECT: begin
                        if (b == CH_GT) begin
                            n_mode = MODE_HEADER;
                        end else begin
                            emit   = 1'b1;
                            ev     = EV_BAD_HEADER;
                            ob     = b;
                            n_mode = MODE_ERROR;
                        end
                    end
                    MODE_HEADER: begin
                        emit = 1'b1;
                        ob   = b;
                        if (b == CH_LF) begin
                            ev     = EV_HDR_END;
                            n_line = sat_inc(r_line);
                            n_mode = MODE_LSTART;
                        end else if (b == CH_CR) begin
                            ev     = EV_HDR_END;
                            n_mode = MODE_HSKIP;
                        end else begin
                            ev     = EV_HDR_BYTE;
                            n_hcnt = sat_inc(r_hcnt);
                        end
                    end
                    MODE_HSKIP: begin
                        if (b == CH_LF) begin
                            n_line = sat_inc(r_line);
                            n_mode = MODE_LSTART;
                        end
                    end
                    MODE_LSTART: begin
                        if (b == CH_GT) begin
                            emit        = 1'b1;
                            ev          = EV_REC_END;
                            use_old_len = 1'b1;
                            n_mode      = MODE_HEADER;
                            n_rec       = sat_inc(r_rec);
                            n_hcnt      = '0;
                            n_scnt      = '0;
                        end else begin
                            do_seq = 1'b1;
                        end
                    end
                    MODE_SEQ: begin
                        do_seq = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        if (do_seq) begin
            ob = b;
            unique case (cls)
                CLS_STRIP: begin
                    emit    = 1'b1;
                    ev      = EV_STRIP;
                    n_stot  = sat_inc(r_stot);
                    of_byte = hist_new;
                    hist_we = s1_go;
                end
                CLS_LEGAL: begin
                    emit   = 1'b1;
                    ev     = EV_SEQ_BYTE;
                    n_scnt = sat_inc(r_scnt);
                end
                CLS_FATAL: begin
                    emit = 1'b1;
                    ev   = (b >= CH_PRINT_MIN) ? EV_ILL_PRINT : EV_ILL_UNPRINT;
                end
                CLS_SILENT: begin
                end
            endcase
            if (cls == CLS_FATAL) begin
                n_mode = MODE_ERROR;
            end else if (b == CH_LF) begin
                n_line = sat_inc(r_line);
                n_mode = MODE_LSTART;
            end else begin
                n_mode = MODE_SEQ;
            end
        end

        n_out.event_res        = ev;
        n_out.out_byte         = ob;
        n_out.header_length    = to_field(use_old_len ? r_hcnt : n_hcnt);
        n_out.sequence_length  = to_field(use_old_len ? r_scnt : n_scnt);
        n_out.record_index     = to_field(r_rec);
        n_out.line_number      = to_field(r_line);
        n_out.stripped_total   = to_field(n_stot);
        n_out.stripped_of_byte = to_field(of_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAP_REGS; i++) begin
                r_map[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_map[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item <= i_in;
        end
        if (s1_go && emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_EXPECT;
            r_line      <= CntOne;
            r_hcnt      <= '0;
            r_scnt      <= '0;
            r_rec       <= '0;
            r_stot      <= '0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_go) begin
                r_mode <= n_mode;
                r_line <= n_line;
                r_hcnt <= n_hcnt;
                r_scnt <= n_scnt;
                r_rec  <= n_rec;
                r_stot <= n_stot;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_hist_write_on_advance: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        hist_we |-> (s1_go && !hist_clear)
    ) else $error("histogram written without an advancing item");

    a_restart_to_expect: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_item.kind == KIND_RESTART) |=>
            (r_mode == MODE_EXPECT && r_stot == '0 && r_line == CntOne)
    ) else $error("restart did not clear the parse state");

    a_error_sticky: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_ERROR && !(s1_go && r_s1_item.kind == KIND_RESTART)) |=>
            (r_mode == MODE_ERROR)
    ) else $error("left the error state without a restart");

    a_out_held: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out))
    ) else $error("pending result overwritten");

    a_line_nonzero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0
    ) else $error("line number reached zero");

endmodule

`default_nettype wire

// File: hw/rtl/frp_hist.sv
// Strip histogram: one synchronous memory with a registered read port,
// per-entry valid bits for a clear of all entries, and write-to-read forwarding.
// Depends on frp_pkg.
`default_nettype none

module frp_hist
    import frp_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_rd_en,
    input  wire logic [BYTE_W-1:0]      i_rd_addr,
    input  wire logic                   i_clear,
    input  wire logic                   i_wr_en,
    input  wire logic [BYTE_W-1:0]      i_wr_addr,
    input  wire logic [COUNT_WIDTH-1:0] i_wr_data,
    output logic      [COUNT_WIDTH-1:0] o_count
);

    logic [COUNT_WIDTH-1:0]   r_mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] r_valid;
    logic [COUNT_WIDTH-1:0]   r_rd_data;
    logic [BYTE_W-1:0]        r_rd_addr;
    logic                     r_fwd_valid;
    logic [BYTE_W-1:0]        r_fwd_addr;
    logic [COUNT_WIDTH-1:0]   r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
            r_fwd_addr <= i_wr_addr;
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_fwd_valid <= i_wr_en;
            end
        end
    end

    // A write issued in the same cycle as the read is not yet in the read data.
    always_comb begin
        if (!r_valid[r_rd_addr]) begin
            o_count = '0;
        end else if (r_fwd_valid && (r_fwd_addr == r_rd_addr)) begin
            o_count = r_fwd_data;
        end else begin
            o_count = r_rd_data;
        end
    end

endmodule

`default_nettype wire
